// File: hdl/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Item types, field widths and configuration register indexes; no dependencies.
package wbps_pkg;

  localparam int ADDR_BITS    = 48;
  localparam int LEN_BITS     = 5;
  localparam int PAT_BYTES    = 16;
  localparam int PAT_IDX_BITS = 4;
  localparam int COUNT_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OCCURRENCE    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_REGION_BASE   = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] match_address;
  } out_item_t;

endpackage

// File: hdl/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: configuration registers,
// region counters and the cell chain. Depends on wbps_pkg, wbps_cell, wbps_out_buf.
//
// Usage: bytes of a region enter on the byte channel (byte_valid/byte_stall),
// one per cycle; last_byte marks the final byte. The pattern (a zero byte is
// a wildcard), its length, the wanted occurrence index and the region base
// are written through the cfg channel, which is always ready.
// At most one result item leaves per byte on the result channel: found with
// the region base plus start offset when the wanted occurrence completes, or
// not found when the last byte arrives without it.
// A result is registered in the output buffer before it leaves on the result channel.
// Throughput: one byte per cycle while byte_stall is low; each window cell compares its byte in
// parallel, and the match chain through MAX_PATTERN cells is combinational.
// A stalled result is held in the output register; one more result fits in
// a skid stage, and byte_stall rises only while that stage is occupied.
// Reset clears the registers to their defaults and empties the output.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_stall,
  input  in_item_t                 byte_item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output out_item_t                result_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [OFFSET_BITS-1:0] SEEN_MAX = '1;

  logic [63:0]            pattern_low;
  logic [63:0]            pattern_high;
  logic [LEN_BITS-1:0]    pattern_length;
  logic [COUNT_BITS-1:0]  occurrence_wanted;
  logic [ADDR_BITS-1:0]   region_base;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0]  matches_counted;
  logic                   reported;

  logic [LEN_BITS-1:0]    used_len;
  logic [7:0]             window [MAX_PATTERN];
  logic [MAX_PATTERN:0]   hit;
  logic                   accept;
  logic                   saturated;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic                   test;
  logic                   report;
  logic [OFFSET_BITS-1:0] offset;
  logic [ADDR_BITS-1:0]   address;
  logic                   res_valid;
  out_item_t              res_item;
  logic                   buf_full;

  assign cfg_ready  = 1'b1;
  assign byte_stall = buf_full;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low       <= '0;
      pattern_high      <= '0;
      pattern_length    <= LEN_BITS'(1);
      occurrence_wanted <= '0;
      region_base       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low       <= cfg_data;
        REG_PATTERN_HIGH: pattern_high      <= cfg_data;
        REG_PATTERN_LEN:  pattern_length    <= cfg_data[LEN_BITS-1:0];
        REG_OCCURRENCE:   occurrence_wanted <= cfg_data[COUNT_BITS-1:0];
        REG_REGION_BASE:  region_base       <= cfg_data[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pattern_length == '0) begin
      used_len = LEN_BITS'(1);
    end else if (pattern_length > LEN_BITS'(MAX_PATTERN)) begin
      used_len = LEN_BITS'(MAX_PATTERN);
    end else begin
      used_len = pattern_length;
    end
  end

  assign hit[0] = 1'b1;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = byte_item.data_byte;
    end else begin : g_link
      assign cell_in = window[i-1];
    end
    wbps_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .shift    (accept),
      .byte_in  (cell_in),
      .hit_in   (hit[i]),
      .pattern  ({pattern_high, pattern_low}),
      .used_len (used_len),
      .byte_out (window[i]),
      .hit_out  (hit[i+1])
    );
  end

  always_comb begin
    saturated       = bytes_seen == SEEN_MAX;
    bytes_seen_next = saturated ? bytes_seen : bytes_seen + OFFSET_BITS'(1);
    test   = !reported && !saturated && hit[MAX_PATTERN]
             && (bytes_seen_next >= OFFSET_BITS'(used_len));
    report = test && (matches_counted == occurrence_wanted);
    offset  = bytes_seen_next - OFFSET_BITS'(used_len);
    address = region_base + ADDR_BITS'(offset);
    res_valid = accept && (report || (byte_item.last_byte && !reported));
    res_item.found         = report;
    res_item.match_address = report ? address : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      matches_counted <= '0;
      reported        <= 1'b0;
    end else if (accept) begin
      if (byte_item.last_byte) begin
        bytes_seen      <= '0;
        matches_counted <= '0;
        reported        <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        if (report) begin
          reported <= 1'b1;
        end else if (test && matches_counted != COUNT_MAX) begin
          matches_counted <= matches_counted + COUNT_BITS'(1);
        end
      end
    end
  end

  wbps_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_item     (res_item),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

// File: hdl/wbps_cell.sv
// One window cell of the scanner: holds a byte, compares its input byte to its aligned
// pattern byte and extends the match chain. Depends on wbps_pkg.
module wbps_cell import wbps_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [7:0]            byte_in,
  input  logic                  hit_in,
  input  logic [8*PAT_BYTES-1:0] pattern,
  input  logic [LEN_BITS-1:0]   used_len,
  output logic [7:0]            byte_out,
  output logic                  hit_out
);

  logic                    active;
  logic [LEN_BITS-1:0]     pat_pos;
  logic [PAT_IDX_BITS-1:0] pat_idx;
  logic [7:0]              pat_byte;
  logic                    eq;

  always_comb begin
    active   = LEN_BITS'(INDEX) < used_len;
    pat_pos  = used_len - LEN_BITS'(INDEX) - LEN_BITS'(1);
    pat_idx  = pat_pos[PAT_IDX_BITS-1:0];
    pat_byte = pattern[8*pat_idx +: 8];
    eq       = !active || (pat_byte == 8'h00) || (byte_in == pat_byte);
    hit_out  = hit_in && eq;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_out <= byte_in;
    end
  end

endmodule

// File: hdl/wbps_out_buf.sv
// Result output register with a skid stage behind it.
// Depends on wbps_pkg.
module wbps_out_buf import wbps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  out_item_t res_item,
  output logic      full,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result_item
);

  logic      skid_valid;
  out_item_t skid_item;
  logic      drain;

  assign drain = !result_valid || !result_stall;
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      result_item <= skid_valid ? skid_item : res_item;
    end else if (res_valid) begin
      skid_item <= res_item;
    end
  end

endmodule

// File: sim/tb_wildcard_byte_pattern_scanner.sv
// Self-checking testbench for wildcard_byte_pattern_scanner: directed table, then random regions.
// Predicts each report from shadow registers and a byte window; depends on wbps_pkg and the RTL.
module tb_wildcard_byte_pattern_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam int SEEN_W = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 750;

  typedef struct packed {
    logic                     is_reg;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] val;
    in_item_t                 it;
    logic                     lit;
    out_item_t                want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  in_item_t byte_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0] pat_len = 5'd1;
  logic [COUNT_BITS-1:0] occ_wanted = '0;
  logic [ADDR_BITS-1:0] base_addr = '0;

  logic [7:0] window_q [PAT_BYTES];
  logic [SEEN_W-1:0] region_bytes;
  logic [COUNT_BITS-1:0] hit_count;
  bit reported;

  out_item_t pending_reports [$];
  out_item_t head;
  step_t plan [$];
  logic [7:0] pool [4];
  int mismatches = 0;
  int cycles = 0;
  int bytes_fed = 0;
  int gap_pct = 28;
  int stall_pct = 28;
  int hold_left = 0;

  wildcard_byte_pattern_scanner #(
    .MAX_PATTERN(PAT_BYTES),
    .OFFSET_BITS(SEEN_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned eff_len();
    if (pat_len == 5'd0) return 1;
    if (pat_len > PAT_BYTES) return PAT_BYTES;
    return 32'(pat_len);
  endfunction

  function automatic logic [7:0] pat_byte(int j);
    logic [63:0] word;
    word = (j < 8) ? pat_lo : pat_hi;
    return word[8*(j%8) +: 8];
  endfunction

  function automatic void clear_region();
    foreach (window_q[i]) window_q[i] = 8'h00;
    region_bytes = '0;
    hit_count = '0;
    reported = 1'b0;
  endfunction

  task automatic scan_byte(input in_item_t it, output bit has_res, output out_item_t res);
    int unsigned len;
    int i;
    bit sat;
    bit hit;
    logic [7:0] p;
    len = eff_len();
    sat = (region_bytes == '1);
    has_res = 1'b0;
    res = '0;
    for (i = PAT_BYTES - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = it.data_byte;
    if (!sat) region_bytes++;
    if (!reported && !sat && region_bytes >= len) begin
      hit = 1'b1;
      for (i = 0; i < len; i++) begin
        p = pat_byte(i);
        if (p != 8'h00 && window_q[len-1-i] != p) hit = 1'b0;
      end
      if (hit) begin
        if (hit_count == occ_wanted) begin
          has_res = 1'b1;
          res.found = 1'b1;
          res.match_address = base_addr + ADDR_BITS'(region_bytes - len);
          reported = 1'b1;
        end else if (hit_count != COUNT_MAX) begin
          hit_count++;
        end
      end
    end
    if (it.last_byte) begin
      if (!reported) begin
        has_res = 1'b1;
        res = '0;
      end
      clear_region();
    end
  endtask

  task automatic report_mismatch(string what, logic [ADDR_BITS-1:0] got,
                                 logic [ADDR_BITS-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report", result_item.match_address, '0);
      end else begin
        head = pending_reports.pop_front();
        if (result_item.found !== head.found)
          report_mismatch("found", ADDR_BITS'(result_item.found), ADDR_BITS'(head.found));
        if (result_item.match_address !== head.match_address)
          report_mismatch("match_address", result_item.match_address, head.match_address);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic push_byte(in_item_t it, bit use_lit = 1'b0, out_item_t lit = '0);
    bit has_res;
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (byte_stall);
    bytes_fed++;
    scan_byte(it, has_res, res);
    if (use_lit) pending_reports.push_back(lit);
    else if (has_res) pending_reports.push_back(res);
  endtask

  task automatic settle();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LOW: pat_lo = val;
      REG_PATTERN_HIGH: pat_hi = val;
      REG_PATTERN_LEN: pat_len = val[4:0];
      REG_OCCURRENCE: occ_wanted = val[COUNT_BITS-1:0];
      REG_REGION_BASE: base_addr = val[ADDR_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] noise64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic new_setup();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0] pb;
    logic [4:0] len;
    logic [COUNT_BITS-1:0] occ;
    logic [ADDR_BITS-1:0] base;
    int b;
    int r;
    foreach (pool[k]) pool[k] = 8'($urandom_range(255));
    lo = '0;
    hi = '0;
    for (b = 0; b < PAT_BYTES; b++) begin
      pb = ($urandom_range(99) < 30) ? 8'h00 : pool[$urandom_range(3)];
      if (b < 8) lo[8*b +: 8] = pb;
      else hi[8*(b-8) +: 8] = pb;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      lo = '1;
      hi = '1;
      pool[0] = 8'hFF;
    end else if (r < 8) begin
      lo = '0;
      hi = '0;
    end
    r = $urandom_range(99);
    if (r < 60) len = 5'($urandom_range(1, 6));
    else if (r < 75) len = 5'($urandom_range(7, 15));
    else if (r < 88) len = 5'd16;
    else len = 5'($urandom_range(31));
    r = $urandom_range(99);
    if (r < 70) occ = COUNT_BITS'($urandom_range(3));
    else if (r < 85) occ = COUNT_BITS'($urandom_range(4, 20));
    else if (r < 92) occ = COUNT_MAX;
    else occ = COUNT_BITS'($urandom());
    r = $urandom_range(99);
    if (r < 15) base = '1 - ADDR_BITS'($urandom_range(40));
    else if (r < 25) base = '0;
    else base = ADDR_BITS'(noise64());
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LEN, CFG_DATA_BITS'({noise64() >> 5, len}));
    write_reg(REG_OCCURRENCE, CFG_DATA_BITS'({noise64() >> COUNT_BITS, occ}));
    write_reg(REG_REGION_BASE, CFG_DATA_BITS'({noise64() >> ADDR_BITS, base}));
  endtask

  task automatic run_region(int n, bit shaped);
    logic [7:0] bytes [$];
    int unsigned len;
    int j;
    in_item_t it;
    len = eff_len();
    while (bytes.size() < n) begin
      if (shaped && $urandom_range(2) == 0) begin
        for (j = 0; j < len; j++)
          bytes.push_back(pat_byte(j) != 8'h00 ? pat_byte(j) : pool[$urandom_range(3)]);
      end else if (shaped && $urandom_range(9) < 7) begin
        bytes.push_back(pool[$urandom_range(3)]);
      end else begin
        bytes.push_back(8'($urandom_range(255)));
      end
    end
    for (j = 0; j < n; j++) begin
      it.data_byte = bytes[j];
      it.last_byte = (j == n - 1);
      push_byte(it);
    end
  endtask

  function automatic step_t reg_row(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic step_t byte_row(logic [7:0] data, logic last);
    step_t s;
    s = '0;
    s.it.data_byte = data;
    s.it.last_byte = last;
    return s;
  endfunction

  function automatic step_t known_row(logic [7:0] data, logic last, logic found,
                                      logic [ADDR_BITS-1:0] addr);
    step_t s;
    s = byte_row(data, last);
    s.lit = 1'b1;
    s.want.found = found;
    s.want.match_address = addr;
    return s;
  endfunction

  initial begin
    int region;
    int n;
    int stop_at;
    clear_region();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan = '{
      known_row(8'hA5, 1'b0, 1'b1, '0),
      byte_row(8'h00, 1'b1),
      reg_row(REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(REG_OCCURRENCE, 64'd1),
      byte_row(8'h12, 1'b0),
      known_row(8'h34, 1'b1, 1'b1, '0),
      reg_row(REG_PATTERN_LOW, 64'h0000_0000_EF00_ADDE),
      reg_row(REG_PATTERN_LEN, 64'd4),
      reg_row(REG_OCCURRENCE, 64'd0),
      reg_row(REG_REGION_BASE, 64'h1000),
      byte_row(8'hDE, 1'b0),
      byte_row(8'hAD, 1'b0),
      byte_row(8'h77, 1'b0),
      byte_row(8'hEF, 1'b1),
      reg_row(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(REG_PATTERN_LEN, 64'd0),
      reg_row(REG_OCCURRENCE, 64'hFFFF_FFFF_FFFF_FFFF),
      known_row(8'hFF, 1'b1, 1'b0, '0),
      reg_row(REG_PATTERN_LOW, 64'd0),
      reg_row(REG_PATTERN_HIGH, 64'd0),
      reg_row(REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(REG_OCCURRENCE, 64'd0),
      reg_row(REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFF),
      byte_row(8'h01, 1'b0), byte_row(8'h02, 1'b0), byte_row(8'h04, 1'b0),
      byte_row(8'h08, 1'b0), byte_row(8'h10, 1'b0), byte_row(8'h20, 1'b0),
      byte_row(8'h40, 1'b0), byte_row(8'h80, 1'b0), byte_row(8'hFE, 1'b0),
      byte_row(8'hFD, 1'b0), byte_row(8'hFB, 1'b0), byte_row(8'hF7, 1'b0),
      byte_row(8'hEF, 1'b0), byte_row(8'hDF, 1'b0), byte_row(8'hBF, 1'b0),
      known_row(8'h7F, 1'b1, 1'b1, '1)
    };
    foreach (plan[k]) begin
      if (plan[k].is_reg) write_reg(plan[k].idx, plan[k].val);
      else push_byte(plan[k].it, plan[k].lit, plan[k].want);
    end

    stop_at = bytes_fed + RANDOM_BYTES;
    region = 0;
    while (bytes_fed < stop_at) begin
      if (region == 0 || $urandom_range(99) < 35) new_setup();
      if (region == 12) begin
        // hold the receiver while single-byte regions keep arriving
        hold_left = 250;
        gap_pct = 0;
        repeat (24) push_byte('{data_byte: 8'($urandom_range(255)), last_byte: 1'b1});
        gap_pct = 28;
      end
      if (region == 20) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      if (region == 32) begin
        gap_pct = 28;
        stall_pct = 28;
      end
      n = ($urandom_range(99) < 80) ? $urandom_range(1, 30) : $urandom_range(31, 90);
      run_region(n, $urandom_range(99) < 75);
      region++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
